/* sv/pal_ups_pkg.sv */
`timescale 1ns / 1ps

package pal_ups_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_SURFACE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SURFACE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_SCALE_FACTOR   = 3'd2;
    localparam logic [2:0] REG_LINE_STRIDE    = 3'd3;
    localparam logic [2:0] REG_FRAME_BASE     = 3'd4;

    // Input commands
    localparam logic CMD_PIXEL         = 1'b0;
    localparam logic CMD_PALETTE_WRITE = 1'b1;

    localparam int COLOR_BITS = 24;

    // Reset values of the configuration registers
    localparam logic [10:0] RST_SURFACE_WIDTH  = 11'd320;
    localparam logic [10:0] RST_SURFACE_HEIGHT = 11'd200;
    localparam logic [2:0]  RST_SCALE_FACTOR   = 3'd1;
    localparam logic [12:0] RST_LINE_STRIDE    = 13'd1024;
    localparam logic [23:0] RST_FRAME_BASE     = 24'd0;

    typedef struct packed {
        logic [10:0] surface_width;
        logic [10:0] surface_height;
        logic [2:0]  scale_factor;
        logic [12:0] line_stride;
        logic [23:0] frame_base_address;
    } cfg_t;

endpackage

/* sv/pal_ups_palette.sv */
`timescale 1ns / 1ps

module pal_ups_palette #(
    parameter int ENTRIES = 256
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [$clog2(ENTRIES)-1:0]            wr_index,
    input  logic [pal_ups_pkg::COLOR_BITS-1:0]    wr_data,
    input  logic                                  rd_en,
    input  logic [$clog2(ENTRIES)-1:0]            rd_index,
    output logic [pal_ups_pkg::COLOR_BITS-1:0]    rd_data
);

    logic [pal_ups_pkg::COLOR_BITS-1:0] mem [ENTRIES];
    logic [pal_ups_pkg::COLOR_BITS-1:0] rd_data_reg;

    // Store a palette entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_index] <= wr_data;
        end
    end

    // Registered read: data shows in the cycle after rd_en, held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_index];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/pal_ups_tracker.sv */
`timescale 1ns / 1ps

module pal_ups_tracker #(
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_HEIGHT   = 1024,
    parameter int ADDRESS_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          restart,
    input  logic                          step,
    input  logic [$clog2(MAX_WIDTH):0]    width,
    input  logic [$clog2(MAX_HEIGHT):0]   height,
    input  logic [2:0]                    scale,
    input  logic [15:0]                   row_step,
    input  logic [ADDRESS_BITS-1:0]       base_address,
    output logic [ADDRESS_BITS-1:0]       pixel_address,
    output logic                          frame_end
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int AW = ADDRESS_BITS;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [AW-1:0] row_start_reg, row_start_next;
    logic [AW-1:0] pixel_reg, pixel_next;
    logic          col_last;
    logic          row_last;
    logic [AW-1:0] row_start_adv;

    assign col_last      = ({1'b0, col_reg} + (CW+1)'(1)) >= width;
    assign row_last      = ({1'b0, row_reg} + (RW+1)'(1)) >= height;
    assign row_start_adv = row_start_reg + AW'(row_step);

    // Restart at the frame base, or advance the raster position by one pixel, wrap at row and frame end
    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        row_start_next = row_start_reg;
        pixel_next     = pixel_reg;
        if (restart)
        begin
            col_next       = '0;
            row_next       = '0;
            row_start_next = base_address;
            pixel_next     = base_address;
        end
        else if (step)
        begin
            if (!col_last)
            begin
                col_next   = col_reg + CW'(1);
                pixel_next = pixel_reg + AW'(scale);
            end
            else if (!row_last)
            begin
                col_next       = '0;
                row_next       = row_reg + RW'(1);
                row_start_next = row_start_adv;
                pixel_next     = row_start_adv;
            end
            else
            begin
                col_next       = '0;
                row_next       = '0;
                row_start_next = base_address;
                pixel_next     = base_address;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            row_start_reg <= '0;
            pixel_reg     <= '0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            row_start_reg <= row_start_next;
            pixel_reg     <= pixel_next;
        end
    end

    assign pixel_address = pixel_reg;
    assign frame_end     = col_last && row_last;

endmodule

/* sv/pal_ups_emitter.sv */
`timescale 1ns / 1ps

module pal_ups_emitter #(
    parameter int ADDRESS_BITS = 24
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  take,
    input  logic [ADDRESS_BITS-1:0]               take_address,
    input  logic                                  take_frame_end,
    input  logic                                  take_no_entry,
    input  logic [pal_ups_pkg::COLOR_BITS-1:0]    rd_data,
    input  logic [2:0]                            scale,
    input  logic [12:0]                           stride,
    output logic                                  ready,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [23:0]                           word_address,
    output logic [pal_ups_pkg::COLOR_BITS-1:0]    pixel_color,
    output logic                                  last_of_block,
    output logic                                  end_of_frame
);

    localparam int AW = ADDRESS_BITS;

    // Lookup stage: waits for palette read data
    logic          a_valid_reg;
    logic [AW-1:0] a_addr_reg;
    logic          a_fe_reg;
    logic          a_no_entry_reg;

    // Block walker
    logic                                job_valid_reg;
    logic [AW-1:0]                       job_row_reg;
    logic [2:0]                          job_dx_reg;
    logic [2:0]                          job_dy_reg;
    logic [pal_ups_pkg::COLOR_BITS-1:0]  job_color_reg;
    logic                                job_fe_reg;

    // Output register
    logic                                out_valid_reg;
    logic [23:0]                         out_addr_reg;
    logic [pal_ups_pkg::COLOR_BITS-1:0]  out_color_reg;
    logic                                out_last_reg;
    logic                                out_eof_reg;

    logic          emit;
    logic          dx_last;
    logic          dy_last;
    logic          job_done;
    logic          job_free;
    logic          a_adv;
    logic [AW-1:0] beat_addr;
    logic [AW+23:0] beat_ext;

    assign emit      = job_valid_reg && (!out_valid_reg || !out_stall);
    assign dx_last   = job_dx_reg == (scale - 3'd1);
    assign dy_last   = job_dy_reg == (scale - 3'd1);
    assign job_done  = emit && dx_last && dy_last;
    assign job_free  = !job_valid_reg || job_done;
    assign a_adv     = a_valid_reg && job_free;
    assign ready     = !a_valid_reg || a_adv;
    assign beat_addr = job_row_reg + AW'(job_dx_reg);
    assign beat_ext  = {24'd0, beat_addr};

    // Hold a pixel until its color is read and the walker is free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (a_adv)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            a_addr_reg     <= take_address;
            a_fe_reg       <= take_frame_end;
            a_no_entry_reg <= take_no_entry;
        end
    end

    // Walk the block: sub-column inner, sub-row outer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            job_dx_reg    <= '0;
            job_dy_reg    <= '0;
        end
        else if (a_adv)
        begin
            job_valid_reg <= 1'b1;
            job_dx_reg    <= '0;
            job_dy_reg    <= '0;
        end
        else if (job_done)
        begin
            job_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            if (dx_last)
            begin
                job_dx_reg <= '0;
                job_dy_reg <= job_dy_reg + 3'd1;
            end
            else
            begin
                job_dx_reg <= job_dx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            job_row_reg   <= a_addr_reg;
            job_color_reg <= a_no_entry_reg ? '0 : rd_data;
            job_fe_reg    <= a_fe_reg;
        end
        else if (emit && dx_last)
        begin
            job_row_reg <= job_row_reg + AW'(stride);
        end
    end

    // Load a beat into the output register, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_addr_reg  <= beat_ext[23:0];
            out_color_reg <= job_color_reg;
            out_last_reg  <= dx_last && dy_last;
            out_eof_reg   <= dx_last && dy_last && job_fe_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign word_address  = out_addr_reg;
    assign pixel_color   = out_color_reg;
    assign last_of_block = out_last_reg;
    assign end_of_frame  = out_eof_reg;

endmodule

/* sv/palette_integer_upscaler.sv */
`timescale 1ns / 1ps
// Path: an accepted pixel's color is read from the palette into the lookup stage, then it
// passes to the block walker and the output register before its first beat shows at out_valid.
// Throughput: one write beat per cycle while out_stall is low; a pixel gives scale*scale beats,
// set by the block walker feeding the single output port. A palette write gives no beat.
// Reset: counters and addresses clear, registers return to their defaults; the palette
// holds no defined contents until written, and no clearing pass is run.

module palette_integer_upscaler #(
    parameter int MAX_WIDTH       = 1024,
    parameter int MAX_HEIGHT      = 1024,
    parameter int PALETTE_ENTRIES = 256,
    parameter int MAX_SCALE       = 4,
    parameter int ADDRESS_BITS    = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_enable,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [7:0]  color_index,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [23:0] word_address,
    output logic [23:0] pixel_color,
    output logic        last_of_block,
    output logic        end_of_frame
);

    localparam int AW = ADDRESS_BITS;
    localparam int IW = $clog2(PALETTE_ENTRIES);
    localparam int WW = $clog2(MAX_WIDTH) + 1;
    localparam int HW = $clog2(MAX_HEIGHT) + 1;

    pal_ups_pkg::cfg_t cfg_reg, cfg_next;
    logic              restart;

    logic              accept;
    logic              take_pixel;
    logic              pal_write;
    logic              in_palette;
    logic              ready;

    logic [WW-1:0]     width;
    logic [HW-1:0]     height;
    logic [2:0]        scale;
    logic [15:0]       row_step;
    logic [AW+23:0]    base_ext;
    logic [AW-1:0]     pixel_address;
    logic              frame_end;
    logic [23:0]       rd_data;

    // Configuration writes; any known register restarts the frame
    always_comb
    begin
        cfg_next = cfg_reg;
        restart  = 1'b0;
        if (cfg_write_enable)
        begin
            case (cfg_index)
                pal_ups_pkg::REG_SURFACE_WIDTH:
                begin
                    cfg_next.surface_width = cfg_data[10:0];
                    restart = 1'b1;
                end
                pal_ups_pkg::REG_SURFACE_HEIGHT:
                begin
                    cfg_next.surface_height = cfg_data[10:0];
                    restart = 1'b1;
                end
                pal_ups_pkg::REG_SCALE_FACTOR:
                begin
                    cfg_next.scale_factor = cfg_data[2:0];
                    restart = 1'b1;
                end
                pal_ups_pkg::REG_LINE_STRIDE:
                begin
                    cfg_next.line_stride = cfg_data[12:0];
                    restart = 1'b1;
                end
                pal_ups_pkg::REG_FRAME_BASE:
                begin
                    cfg_next.frame_base_address = cfg_data;
                    restart = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.surface_width      <= pal_ups_pkg::RST_SURFACE_WIDTH;
            cfg_reg.surface_height     <= pal_ups_pkg::RST_SURFACE_HEIGHT;
            cfg_reg.scale_factor       <= pal_ups_pkg::RST_SCALE_FACTOR;
            cfg_reg.line_stride        <= pal_ups_pkg::RST_LINE_STRIDE;
            cfg_reg.frame_base_address <= pal_ups_pkg::RST_FRAME_BASE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Clamp geometry: zero counts as one, large values saturate
    always_comb
    begin
        if (cfg_reg.surface_width == '0)
            width = WW'(1);
        else if (32'(cfg_reg.surface_width) > 32'(MAX_WIDTH))
            width = WW'(MAX_WIDTH);
        else
            width = WW'(cfg_reg.surface_width);

        if (cfg_reg.surface_height == '0)
            height = HW'(1);
        else if (32'(cfg_reg.surface_height) > 32'(MAX_HEIGHT))
            height = HW'(MAX_HEIGHT);
        else
            height = HW'(cfg_reg.surface_height);

        if (cfg_reg.scale_factor == '0)
            scale = 3'd1;
        else if ({1'b0, cfg_reg.scale_factor} > 4'(MAX_SCALE))
            scale = 3'(MAX_SCALE);
        else
            scale = cfg_reg.scale_factor;
    end

    // Restart takes a base written in the same cycle
    assign row_step = 16'(scale) * 16'(cfg_reg.line_stride);
    assign base_ext = {{AW{1'b0}}, cfg_next.frame_base_address};

    // Input beat decode
    assign in_stall   = !ready;
    assign accept     = in_valid && ready;
    assign in_palette = {1'b0, color_index} < 9'(PALETTE_ENTRIES);
    assign take_pixel = accept && (command == pal_ups_pkg::CMD_PIXEL);
    assign pal_write  = accept && (command == pal_ups_pkg::CMD_PALETTE_WRITE) && in_palette;

    pal_ups_palette #(
        .ENTRIES (PALETTE_ENTRIES)
    ) u_palette (
        .clk      (clk),
        .wr_en    (pal_write),
        .wr_index (color_index[IW-1:0]),
        .wr_data  ({red, green, blue}),
        .rd_en    (take_pixel),
        .rd_index (color_index[IW-1:0]),
        .rd_data  (rd_data)
    );

    pal_ups_tracker #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_tracker (
        .clk           (clk),
        .rst_n         (rst_n),
        .restart       (restart),
        .step          (take_pixel),
        .width         (width),
        .height        (height),
        .scale         (scale),
        .row_step      (row_step),
        .base_address  (base_ext[AW-1:0]),
        .pixel_address (pixel_address),
        .frame_end     (frame_end)
    );

    pal_ups_emitter #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_emitter (
        .clk            (clk),
        .rst_n          (rst_n),
        .take           (take_pixel),
        .take_address   (pixel_address),
        .take_frame_end (frame_end),
        .take_no_entry  (!in_palette),
        .rd_data        (rd_data),
        .scale          (scale),
        .stride         (cfg_reg.line_stride),
        .ready          (ready),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .word_address   (word_address),
        .pixel_color    (pixel_color),
        .last_of_block  (last_of_block),
        .end_of_frame   (end_of_frame)
    );

endmodule

/* sv/pal_ups_checker.sv */
`timescale 1ns / 1ps

module pal_ups_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [23:0] word_address,
    input logic [23:0] pixel_color,
    input logic        last_of_block,
    input logic        end_of_frame
);

    // Frame end only marks the final beat of a block
    a_eof_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_frame |-> last_of_block)
        else $error("end_of_frame without last_of_block");

    // A block's beats leave without gaps
    a_block_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_block |=> out_valid)
        else $error("gap inside a block");

    // All beats of one block carry one color
    a_block_color: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_block |=> pixel_color == $past(pixel_color))
        else $error("color changed inside a block");

    // A stalled beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(word_address))
        else $error("stalled output beat changed");

endmodule

bind palette_integer_upscaler pal_ups_checker u_pal_ups_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .word_address  (word_address),
    .pixel_color   (pixel_color),
    .last_of_block (last_of_block),
    .end_of_frame  (end_of_frame)
);
